[hw/rtl/b64e_pkg.sv]
// b64e_pkg: types, constants and the alphabet mapping of the base64 stream encoder
// no dependencies; imported by every module of the encoder but the checker
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR    = 7'h3D;
    localparam logic [1:0] PH_FIRST    = 2'd0;
    localparam logic [1:0] PH_SECOND   = 2'd1;
    localparam logic [1:0] PH_THIRD    = 2'd2;

    // one decoded input byte: up to two symbols, then padding
    typedef struct packed {
        logic [5:0] sym0;
        logic [5:0] sym1;
        logic       nsym_m1;
        logic [1:0] nchr_m1;
    } t_job;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'h61 + {1'b0, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 7'h30 + {1'b0, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

[hw/rtl/b64e_front.sv]
// b64e_front: group position tracking and symbol extraction for each input beat
// depends on b64e_pkg
module b64e_front import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output t_job       o_job
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;

    always_comb begin
        o_job   = '0;
        n_phase = r_phase;
        n_carry = r_carry;
        case (r_phase)
            PH_SECOND: begin
                o_job.sym0    = {r_carry[1:0], i_data_byte[7:4]};
                o_job.sym1    = {i_data_byte[3:0], 2'b00};
                o_job.nsym_m1 = i_final_byte;
                o_job.nchr_m1 = i_final_byte ? 2'd2 : 2'd0;
                n_phase       = PH_THIRD;
                n_carry       = i_data_byte[3:0];
            end
            PH_THIRD: begin
                o_job.sym0    = {r_carry, i_data_byte[7:6]};
                o_job.sym1    = i_data_byte[5:0];
                o_job.nsym_m1 = 1'b1;
                o_job.nchr_m1 = 2'd1;
                n_phase       = PH_FIRST;
                n_carry       = 4'd0;
            end
            default: begin
                o_job.sym0    = i_data_byte[7:2];
                o_job.sym1    = {i_data_byte[1:0], 4'b0000};
                o_job.nsym_m1 = i_final_byte;
                o_job.nchr_m1 = i_final_byte ? 2'd3 : 2'd0;
                n_phase       = PH_SECOND;
                n_carry       = {2'b00, i_data_byte[1:0]};
            end
        endcase
        // end of message
        if (i_final_byte) begin
            n_phase = PH_FIRST;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_carry <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

[hw/rtl/b64e_jobq.sv]
// b64e_jobq: two-entry queue of decoded beats between front and back
// depends on b64e_pkg
module b64e_jobq import b64e_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_job,
    input  logic i_rd,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

endmodule

[hw/rtl/b64e_back.sv]
// b64e_back: walks each queued job one character per cycle into a two-entry output queue,
// stalling while that queue is full or no job waits; depends on b64e_pkg
module b64e_back import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_job_valid,
    output logic       o_job_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [6:0] o_ascii_char,
    output logic       o_run_end
);

    logic [1:0] r_idx;
    logic [6:0] r_q_char [2];
    logic       r_q_end  [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic       emit, last, rd;
    logic [6:0] chr;

    assign rd    = i_pop && !o_empty;
    assign emit  = i_job_valid && (r_cnt != 2'd2);
    assign last  = (r_idx == i_job.nchr_m1);
    assign o_job_pop = emit && last;

    always_comb begin
        if (r_idx[1] || (r_idx[0] && !i_job.nsym_m1)) begin
            chr = PAD_CHAR;
        end else begin
            chr = b64_char(r_idx[0] ? i_job.sym1 : i_job.sym0);
        end
    end

    assign o_empty      = (r_cnt == 2'd0);
    assign o_ascii_char = r_q_char[r_rp];
    assign o_run_end    = r_q_end[r_rp];

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_q_char[r_wp] <= chr;
            r_q_end[r_wp]  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (emit) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
                r_wp  <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, emit} - {1'b0, rd};
        end
    end

endmodule

[hw/rtl/base64_stream_encoder.sv]
// base64_stream_encoder: an accepted byte is registered in the job queue and its characters
// in the output queue; throughput is one character per cycle while output is popped,
// set by the back walker; one to four characters per byte, about 1.33 in a long message
// a two-entry job queue and a two-entry output queue let each side stall on its own
// synchronous active-low reset empties both queues and returns to the start of a group
// depends on b64e_pkg, b64e_front, b64e_jobq, b64e_back
module base64_stream_encoder import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] o_ascii_char,
    output logic       o_run_end
);

    t_job front_job, head_job;
    logic accept, jq_empty, job_pop;

    assign accept = push && !full;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_job        (front_job)
    );

    b64e_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_job   (front_job),
        .i_rd    (job_pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (jq_empty)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_job_valid  (!jq_empty),
        .o_job_pop    (job_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_ascii_char (o_ascii_char),
        .o_run_end    (o_run_end)
    );

endmodule

[hw/rtl/b64e_checker.sv]
// b64e_checker: port-level checks of the base64 stream encoder, bound to the top level
// depends on base64_stream_encoder
module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [6:0] o_ascii_char,
    input logic       o_run_end
);

    // both sides open after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // a waiting beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_ascii_char) && $stable(o_run_end))
        else $error("stalled output beat changed");

    // only alphabet symbols or padding
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_ascii_char >= 7'h41 && o_ascii_char <= 7'h5A)
                || (o_ascii_char >= 7'h61 && o_ascii_char <= 7'h7A)
                || (o_ascii_char >= 7'h30 && o_ascii_char <= 7'h39)
                || o_ascii_char == 7'h2B || o_ascii_char == 7'h2F
                || o_ascii_char == 7'h3D)
        else $error("illegal output character");

    // padding is never followed within a run by a symbol
    a_pad_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_ascii_char == 7'h3D && !o_run_end ##1 !empty
        |-> o_ascii_char == 7'h3D)
        else $error("symbol after padding");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_ascii_char (o_ascii_char),
    .o_run_end    (o_run_end)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// testbench for base64_stream_encoder: directed table of byte messages, then random messages
// under four idling patterns, every character checked against the row text or a local base64 predictor
// depends on b64e_pkg and base64_stream_encoder
module testbench import b64e_pkg::*;;

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 78;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_out_char;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        string      text;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_data_byte;
    logic       i_final_byte;
    logic       empty;
    logic       pop;
    logic [6:0] o_ascii_char;
    logic       o_run_end;

    t_out_char  pending_chars[$];
    string      known_text[$];
    logic [1:0] grp_pos;
    logic [3:0] leftover;
    int         errors;
    int         cycle_count;
    int         sender_idle_pct;
    int         receiver_stall_pct;

    t_row directed_rows [22] = '{
        '{8'h00, 1'b1, "AA=="},
        '{8'hFF, 1'b1, "/w=="},
        '{8'h00, 1'b0, "A"},
        '{8'h00, 1'b0, "A"},
        '{8'h00, 1'b1, "AA"},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b1, "//"},
        '{8'hFF, 1'b0, "/"},
        '{8'hFF, 1'b1, "/8="},
        '{8'h4D, 1'b0, "T"},
        '{8'h61, 1'b0, "W"},
        '{8'h6E, 1'b1, "Fu"},
        '{8'h4D, 1'b0, "T"},
        '{8'h61, 1'b1, "WE="},
        '{8'h80, 1'b0, ""},
        '{8'h01, 1'b0, ""},
        '{8'h7F, 1'b0, ""},
        '{8'hFE, 1'b0, ""},
        '{8'h55, 1'b0, ""},
        '{8'hAA, 1'b0, ""},
        '{8'h3C, 1'b1, ""}
    };

    base64_stream_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_final_byte(i_final_byte),
        .empty       (empty),
        .pop         (pop),
        .o_ascii_char(o_ascii_char),
        .o_run_end   (o_run_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [6:0] symbol(input logic [5:0] v);
        byte c;
        c = ALPHABET[v];
        return c[6:0];
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic fin,
                                        ref logic [6:0] chars[$]);
        chars = {};
        case (grp_pos)
            PH_SECOND: begin
                chars.insert(chars.size(), symbol({leftover[1:0], b[7:4]}));
                leftover = b[3:0];
                grp_pos  = PH_THIRD;
                if (fin) begin
                    chars.insert(chars.size(), symbol({leftover, 2'b00}));
                    chars.insert(chars.size(), PAD_CHAR);
                end
            end
            PH_THIRD: begin
                chars.insert(chars.size(), symbol({leftover, b[7:6]}));
                chars.insert(chars.size(), symbol(b[5:0]));
                leftover = 4'd0;
                grp_pos  = PH_FIRST;
            end
            default: begin
                chars.insert(chars.size(), symbol(b[7:2]));
                leftover = {2'b00, b[1:0]};
                grp_pos  = PH_SECOND;
                if (fin) begin
                    chars.insert(chars.size(), symbol({leftover[1:0], 4'd0}));
                    chars.insert(chars.size(), PAD_CHAR);
                    chars.insert(chars.size(), PAD_CHAR);
                end
            end
        endcase
        if (fin) begin
            grp_pos  = PH_FIRST;
            leftover = 4'd0;
        end
    endfunction

    // accepted beats on both sides, sampled at the rising edge
    always @(posedge i_clk) begin : beat_monitor
        logic [6:0] chars[$];
        string      text;
        byte        c;
        t_out_char  want;
        t_out_char  item;
        if (i_rst_n && push && !full) begin
            encode_byte(i_data_byte, i_final_byte, chars);
            text = known_text.pop_front();
            if (text.len() != 0) begin
                chars = {};
                for (int k = 0; k < text.len(); k++) begin
                    c = text[k];
                    chars.insert(chars.size(), c[6:0]);
                end
            end
            for (int k = 0; k < chars.size(); k++) begin
                item.ch   = chars[k];
                item.last = logic'(k == chars.size() - 1);
                pending_chars.insert(pending_chars.size(), item);
            end
        end
        if (i_rst_n && pop && !empty) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char expected none got %h run_end %b",
                         $time, o_ascii_char, o_run_end);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                if (o_ascii_char !== want.ch) begin
                    $display("%0t: ascii_char expected %h got %h", $time, want.ch, o_ascii_char);
                    errors++;
                end
                if (o_run_end !== want.last) begin
                    $display("%0t: run_end expected %b got %b", $time, want.last, o_run_end);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("base64_stream_encoder test failed");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic fin, input string text);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        known_text.insert(known_text.size(), text);
        push         <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        // full only moves at the rising edge, so it is settled here
        while (full) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int         msg_len;
        int         sent;
        logic [7:0] b;
        i_rst_n            = 1'b0;
        push               = 1'b0;
        pop                = 1'b0;
        i_data_byte        = 8'd0;
        i_final_byte       = 1'b0;
        errors             = 0;
        cycle_count        = 0;
        grp_pos            = PH_FIRST;
        leftover           = 4'd0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].b, directed_rows[r].fin, directed_rows[r].text);
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
                default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                msg_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 10);
                for (int k = 0; k < msg_len; k++) begin
                    case ($urandom_range(0, 7))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        default: b = 8'($urandom);
                    endcase
                    send_byte(b, logic'(k == msg_len - 1), "");
                end
                sent += msg_len;
            end
        end

        push <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("base64_stream_encoder test passed");
        end else begin
            $display("base64_stream_encoder test failed");
        end
        $finish;
    end

endmodule
